>>> rtl/xamd_pkg.sv
`default_nettype none

package xamd_pkg;

   localparam logic [7:0] PFX_OPSIZE   = 8'd102;
   localparam logic [7:0] PFX_ADDRSIZE = 8'd103;
   localparam logic [7:0] OPC_MASK     = 8'hC7;
   localparam logic [7:0] OPC_MAX      = 8'd56;
   localparam logic [2:0] RM_DISP16    = 3'd6;
   localparam logic [2:0] RM_DISP32    = 3'd5;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [1:0] MOD_REG      = 2'd3;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISPW    = 2'd2;
   localparam logic       KIND_ALU     = 1'b0;
   localparam logic       KIND_UNKNOWN = 1'b1;
   localparam logic [1:0] PFX_BIT_OP   = 2'b01;
   localparam logic [1:0] PFX_BIT_ADDR = 2'b10;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_AFTER66 = 3'd1,
      PH_AFTER67 = 3'd2,
      PH_MODRM   = 3'd3,
      PH_SIB     = 3'd4,
      PH_DISP    = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  prefixes;
      logic [2:0]  opcode_index;
      logic [7:0]  modrm;
      logic [7:0]  sib;
      logic [31:0] disp_accum;
      logic [2:0]  disp_left;
      logic [3:0]  byte_count;
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  alu_op;
      logic [1:0]  prefix_flags;
      logic [1:0]  mode;
      logic [2:0]  reg_field;
      logic [2:0]  rm_field;
      logic        has_sib;
      logic [1:0]  sib_scale;
      logic [2:0]  sib_index;
      logic [2:0]  sib_base;
      logic [31:0] displacement;
      logic [3:0]  length;
   } result_type;

   function automatic logic sib_present(input logic [1:0] pfx, input logic [7:0] modrm);
      return !pfx[1] && (modrm[7:6] != MOD_REG) && (modrm[2:0] == RM_SIB);
   endfunction

   function automatic logic [2:0] disp_size(input logic [1:0] pfx, input logic [7:0] modrm,
                                            input logic [7:0] sib);
      logic [2:0] n;
      n = 3'd0;
      if (modrm[7:6] == MOD_REG) begin
         n = 3'd0;
      end else if (modrm[7:6] == MOD_DISP8) begin
         n = 3'd1;
      end else if (pfx[1]) begin
         if (modrm[7:6] == MOD_DISPW || modrm[2:0] == RM_DISP16) n = 3'd2;
      end else begin
         if (modrm[7:6] == MOD_DISPW || modrm[2:0] == RM_DISP32) n = 3'd4;
         else if (modrm[2:0] == RM_SIB && sib[2:0] == RM_DISP32) n = 3'd4;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/xamd_req_if.sv
`default_nettype none

interface xamd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/xamd_rsp_if.sv
`default_nettype none

interface xamd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  alu_op;
   logic [1:0]  prefix_flags;
   logic [1:0]  mode;
   logic [2:0]  reg_field;
   logic [2:0]  rm_field;
   logic        has_sib;
   logic [1:0]  sib_scale;
   logic [2:0]  sib_index;
   logic [2:0]  sib_base;
   logic [31:0] displacement;
   logic [3:0]  length;

   modport source (output valid, output kind, output alu_op, output prefix_flags, output mode,
                   output reg_field, output rm_field, output has_sib, output sib_scale,
                   output sib_index, output sib_base, output displacement, output length,
                   input ready);
   modport sink (input valid, input kind, input alu_op, input prefix_flags, input mode,
                 input reg_field, input rm_field, input has_sib, input sib_scale,
                 input sib_index, input sib_base, input displacement, input length,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/xamd_step.sv
`default_nettype none

module xamd_step (
   input  xamd_pkg::state_type  cur,
   input  logic [7:0]           code_byte,
   output xamd_pkg::state_type  nxt,
   output logic                 emit,
   output xamd_pkg::result_type res
);

   function automatic xamd_pkg::result_type alu_result(
      input logic [2:0] op, input logic [1:0] pfx, input logic [7:0] modrm,
      input logic [7:0] sib, input logic [31:0] disp, input logic [3:0] cnt);
      xamd_pkg::result_type r;
      logic s;
      s = xamd_pkg::sib_present(pfx, modrm);
      r = '0;
      r.kind         = xamd_pkg::KIND_ALU;
      r.alu_op       = op;
      r.prefix_flags = pfx;
      r.mode         = modrm[7:6];
      r.reg_field    = modrm[5:3];
      r.rm_field     = modrm[2:0];
      r.has_sib      = s;
      r.sib_scale    = s ? sib[7:6] : 2'd0;
      r.sib_index    = s ? sib[5:3] : 3'd0;
      r.sib_base     = s ? sib[2:0] : 3'd0;
      r.displacement = disp;
      r.length       = cnt;
      return r;
   endfunction

   xamd_pkg::state_type base;
   logic [3:0]          count;
   logic [3:0]          cnt_use;
   logic                chk_opc;
   logic [2:0]          n_disp;
   logic [7:0]          addr_modrm;
   logic [7:0]          addr_sib;
   logic                addr_done;
   logic [1:0]          pos;
   logic [31:0]         accum;
   logic [2:0]          left;

   always_comb begin
      count      = cur.byte_count + 4'd1;
      cnt_use    = count;
      base       = cur;
      nxt        = cur;
      emit       = 1'b0;
      res        = '0;
      chk_opc    = 1'b0;
      addr_done  = 1'b0;
      addr_modrm = cur.modrm;
      addr_sib   = cur.sib;
      pos        = 2'd0;
      accum      = cur.disp_accum;
      left       = cur.disp_left;
      unique case (cur.phase)
         xamd_pkg::PH_MODRM: begin
            nxt.modrm      = code_byte;
            nxt.byte_count = count;
            addr_modrm     = code_byte;
            if (xamd_pkg::sib_present(cur.prefixes, code_byte)) nxt.phase = xamd_pkg::PH_SIB;
            else addr_done = 1'b1;
         end
         xamd_pkg::PH_SIB: begin
            nxt.sib        = code_byte;
            nxt.byte_count = count;
            addr_sib       = code_byte;
            addr_done      = 1'b1;
         end
         xamd_pkg::PH_DISP: begin
            nxt.byte_count = count;
            pos   = 2'(xamd_pkg::disp_size(cur.prefixes, cur.modrm, cur.sib) - cur.disp_left);
            accum = cur.disp_accum | (32'(code_byte) << {pos, 3'b000});
            left  = cur.disp_left - 3'd1;
            nxt.disp_accum = accum;
            nxt.disp_left  = left;
            if (left == 3'd0) begin
               emit = 1'b1;
               res  = alu_result(cur.opcode_index, cur.prefixes, cur.modrm, cur.sib, accum,
                                 count);
               nxt  = '0;
            end
         end
         xamd_pkg::PH_AFTER66: begin
            if (code_byte == xamd_pkg::PFX_ADDRSIZE) begin
               nxt.prefixes   = cur.prefixes | xamd_pkg::PFX_BIT_ADDR;
               nxt.phase      = xamd_pkg::PH_AFTER67;
               nxt.byte_count = count;
            end else begin
               chk_opc = 1'b1;
            end
         end
         xamd_pkg::PH_AFTER67: chk_opc = 1'b1;
         default: begin
            base    = '0;
            cnt_use = 4'd1;
            nxt     = '0;
            if (code_byte == xamd_pkg::PFX_OPSIZE) begin
               nxt.prefixes   = xamd_pkg::PFX_BIT_OP;
               nxt.phase      = xamd_pkg::PH_AFTER66;
               nxt.byte_count = 4'd1;
            end else if (code_byte == xamd_pkg::PFX_ADDRSIZE) begin
               nxt.prefixes   = xamd_pkg::PFX_BIT_ADDR;
               nxt.phase      = xamd_pkg::PH_AFTER67;
               nxt.byte_count = 4'd1;
            end else begin
               chk_opc = 1'b1;
            end
         end
      endcase

      n_disp = xamd_pkg::disp_size(cur.prefixes, addr_modrm, addr_sib);
      if (addr_done) begin
         if (n_disp == 3'd0) begin
            emit = 1'b1;
            res  = alu_result(cur.opcode_index, cur.prefixes, addr_modrm, addr_sib,
                              cur.disp_accum, count);
            nxt  = '0;
         end else begin
            nxt.disp_accum = '0;
            nxt.disp_left  = n_disp;
            nxt.phase      = xamd_pkg::PH_DISP;
         end
      end

      if (chk_opc) begin
         if ((code_byte & xamd_pkg::OPC_MASK) == 8'd0 && code_byte <= xamd_pkg::OPC_MAX) begin
            nxt              = base;
            nxt.opcode_index = code_byte[5:3];
            nxt.byte_count   = cnt_use;
            nxt.phase        = xamd_pkg::PH_MODRM;
         end else begin
            emit             = 1'b1;
            res              = '0;
            res.kind         = xamd_pkg::KIND_UNKNOWN;
            res.prefix_flags = base.prefixes;
            res.displacement = 32'(code_byte);
            res.length       = cnt_use;
            nxt              = '0;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/x86_alu_modrm_decoder_core.sv
// x86 alu r/m8,r8 decoder, one code byte per transfer
// req_ch: code bytes of the instruction stream (valid/ready, code_byte)
// rsp_ch: one decoded instruction per transfer, sent on the byte that
//   completes it; a byte that cannot start an instruction is sent alone
//   as kind unknown with the byte in displacement
// a 0x66 prefix and then a 0x67 prefix may precede the opcode
// datapath: a byte is taken into the input register, decoded there against
//   the parser state and its result lands in the output register
// throughput: one byte per cycle while rsp_ch does not stall; the parser
//   state update is the one short decode step between the input and
//   output registers
// when rsp_ch stalls, the output register holds its result and the input
//   register holds one more byte, then req_ch.ready drops
// reset: clears both stages and returns the parser to expecting a prefix
//   or opcode with no prefixes and an empty byte count
`default_nettype none

module x86_alu_modrm_decoder_core (
   input  logic              clock,
   input  logic              reset,
   xamd_req_if.sink          req_ch,
   xamd_rsp_if.source        rsp_ch
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   xamd_pkg::result_type out_ff;
   xamd_pkg::state_type  state_ff;
   xamd_pkg::state_type  state_in;
   xamd_pkg::state_type  step_nxt;
   xamd_pkg::result_type step_res;
   logic                 step_emit;
   logic                 advance;
   logic                 take;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   xamd_step u_step (
      .cur       (state_ff),
      .code_byte (in_byte_ff),
      .nxt       (step_nxt),
      .emit      (step_emit),
      .res       (step_res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b0;
         if (in_valid_ff) begin
            state_in     = step_nxt;
            out_valid_in = step_emit;
         end
      end
      if (take) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) in_byte_ff <= req_ch.code_byte;
      if (advance && in_valid_ff && step_emit) out_ff <= step_res;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.kind         = out_ff.kind;
   assign rsp_ch.alu_op       = out_ff.alu_op;
   assign rsp_ch.prefix_flags = out_ff.prefix_flags;
   assign rsp_ch.mode         = out_ff.mode;
   assign rsp_ch.reg_field    = out_ff.reg_field;
   assign rsp_ch.rm_field     = out_ff.rm_field;
   assign rsp_ch.has_sib      = out_ff.has_sib;
   assign rsp_ch.sib_scale    = out_ff.sib_scale;
   assign rsp_ch.sib_index    = out_ff.sib_index;
   assign rsp_ch.sib_base     = out_ff.sib_base;
   assign rsp_ch.displacement = out_ff.displacement;
   assign rsp_ch.length       = out_ff.length;

endmodule

`default_nettype wire
